// File: rtl/hacfp_pkg.sv
// Shared types and constants of the hex ASCII command frame parser.
`default_nettype none

package hacfp_pkg;

  // Largest payload that is not flagged as oversize.
  localparam int unsigned MAX_PAYLOAD = 10;

  // A length byte above this value is flagged as oversize.
  localparam logic [7:0] OVERSIZE_LIMIT = 8'(MAX_PAYLOAD + 3);

  // Bytes that a frame carries besides its data: command, length and checksum.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

  // Range of command codes that the block recognizes.
  localparam logic [7:0] CMD_FIRST = 8'h01;
  localparam logic [7:0] CMD_LAST  = 8'h04;

  // ASCII ranges of hex digits and the offsets that turn them into nibbles.
  localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
  localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
  localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
  localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
  localparam logic [7:0] CHAR_LOWER_HI = 8'h66;
  localparam logic [7:0] OFFSET_UPPER  = 8'h37;
  localparam logic [7:0] OFFSET_LOWER  = 8'h57;

  // Kind of a decoded byte as it appears on the result channel.
  typedef enum logic [1:0] {
    KIND_CMD      = 2'd0,
    KIND_LEN      = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_CHECKSUM = 2'd3
  } byte_kind_t;

  // Where the framer stands within a frame.
  typedef enum logic [1:0] {
    POS_CMD  = 2'd0,
    POS_LEN  = 2'd1,
    POS_BODY = 2'd2
  } frame_pos_t;

  // One result word.
  typedef struct packed {
    logic [7:0] byte_value;
    byte_kind_t byte_kind;
    logic [7:0] data_index;
    logic       frame_end;
    logic       checksum_ok;
    logic       command_known;
    logic       hex_error;
    logic       oversize;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/hacfp_hex_decode.sv
// Decoder from one ASCII character to a hex nibble with a bad-digit flag.
`default_nettype none

module hacfp_hex_decode (
  input  wire logic [7:0] char_in,
  output logic      [3:0] nibble,
  output logic            bad
);
  import hacfp_pkg::*;

  logic is_digit;
  logic is_upper;
  logic is_lower;
  logic [7:0] value;

  assign is_digit = (char_in >= CHAR_DIGIT_LO) && (char_in <= CHAR_DIGIT_HI);
  assign is_upper = (char_in >= CHAR_UPPER_LO) && (char_in <= CHAR_UPPER_HI);
  assign is_lower = (char_in >= CHAR_LOWER_LO) && (char_in <= CHAR_LOWER_HI);

  // A character that is not a hex digit decodes as zero.
  always_comb begin
    priority if (is_digit) begin
      value = char_in - CHAR_DIGIT_LO;
    end else if (is_upper) begin
      value = char_in - OFFSET_UPPER;
    end else if (is_lower) begin
      value = char_in - OFFSET_LOWER;
    end else begin
      value = 8'h00;
    end
  end

  assign nibble = value[3:0];
  assign bad    = !(is_digit || is_upper || is_lower);

endmodule

`default_nettype wire

// File: rtl/hacfp_framer.sv
// Pairing of nibbles into bytes and framing state of the parser.
`default_nettype none

module hacfp_framer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [3:0]        nibble,
  input  wire logic              nibble_bad,
  output logic                   second_digit,
  output logic                   res_fire,
  output hacfp_pkg::result_t     res
);
  import hacfp_pkg::*;

  logic       second_digit_r, second_digit_nxt;
  logic [3:0] high_nibble_r,  high_nibble_nxt;
  logic       high_bad_r,     high_bad_nxt;
  frame_pos_t position_r,     position_nxt;
  logic [7:0] payload_cnt_r,  payload_cnt_nxt;
  logic [7:0] frame_len_r,    frame_len_nxt;
  logic [7:0] run_sum_r,      run_sum_nxt;
  logic [7:0] cmd_byte_r,     cmd_byte_nxt;

  logic [7:0] value;
  logic       more_data;

  assign value = {high_nibble_r, nibble};

  // payload_cnt < len - 3, written so that a length below three yields no data.
  assign more_data = ({1'b0, payload_cnt_r} + FRAME_OVERHEAD) < {1'b0, frame_len_r};

  always_comb begin
    second_digit_nxt = second_digit_r;
    high_nibble_nxt  = high_nibble_r;
    high_bad_nxt     = high_bad_r;
    position_nxt     = position_r;
    payload_cnt_nxt  = payload_cnt_r;
    frame_len_nxt    = frame_len_r;
    run_sum_nxt      = run_sum_r;
    cmd_byte_nxt     = cmd_byte_r;

    res               = '0;
    res.byte_value    = value;
    res.hex_error     = high_bad_r || nibble_bad;

    if (!second_digit_r) begin
      high_nibble_nxt  = nibble;
      high_bad_nxt     = nibble_bad;
      second_digit_nxt = 1'b1;
    end else begin
      second_digit_nxt = 1'b0;
      unique case (position_r)
        POS_CMD: begin
          res.byte_kind = KIND_CMD;
          cmd_byte_nxt  = value;
          run_sum_nxt   = value;
          position_nxt  = POS_LEN;
        end
        POS_LEN: begin
          res.byte_kind = KIND_LEN;
          res.oversize  = value > OVERSIZE_LIMIT;
          frame_len_nxt = value;
          run_sum_nxt   = run_sum_r + value;
          position_nxt  = POS_BODY;
        end
        POS_BODY: begin
          if (more_data) begin
            res.byte_kind   = KIND_DATA;
            res.data_index  = payload_cnt_r;
            payload_cnt_nxt = payload_cnt_r + 8'd1;
            run_sum_nxt     = run_sum_r + value;
          end else begin
            res.byte_kind     = KIND_CHECKSUM;
            res.frame_end     = 1'b1;
            res.checksum_ok   = run_sum_r == value;
            res.command_known = (cmd_byte_r >= CMD_FIRST) && (cmd_byte_r <= CMD_LAST);
            res.oversize      = frame_len_r > OVERSIZE_LIMIT;
            position_nxt      = POS_CMD;
            payload_cnt_nxt   = 8'd0;
            run_sum_nxt       = 8'd0;
          end
        end
        default: begin
          position_nxt = POS_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_digit_r <= 1'b0;
      high_nibble_r  <= 4'd0;
      high_bad_r     <= 1'b0;
      position_r     <= POS_CMD;
      payload_cnt_r  <= 8'd0;
      frame_len_r    <= 8'd0;
      run_sum_r      <= 8'd0;
      cmd_byte_r     <= 8'd0;
    end else if (step) begin
      second_digit_r <= second_digit_nxt;
      high_nibble_r  <= high_nibble_nxt;
      high_bad_r     <= high_bad_nxt;
      position_r     <= position_nxt;
      payload_cnt_r  <= payload_cnt_nxt;
      frame_len_r    <= frame_len_nxt;
      run_sum_r      <= run_sum_nxt;
      cmd_byte_r     <= cmd_byte_nxt;
    end
  end

  assign second_digit = second_digit_r;
  assign res_fire     = step && second_digit_r;

endmodule

`default_nettype wire

// File: rtl/hex_ascii_command_frame_parser.sv
// Top level of the hex ASCII command frame parser.
`default_nettype none

// The parser takes one ASCII character per word on the input channel and
// pairs consecutive characters into bytes, the first character being the
// high nibble; 0-9, A-F and a-f are hex digits, anything else decodes as
// zero and raises hex_error on the byte of its pair. Bytes are framed as
// command, length, (length - 3) data bytes and checksum, and every byte
// leaves as one result word with its kind; the first character of a pair
// produces no word. On the checksum word frame_end is set, checksum_ok
// tells whether the 8-bit sum of command, length and data matches, and
// command_known whether the command is 1 to 4. oversize flags a length
// above the payload limit plus three on the length and checksum words,
// while framing still follows the length. After the checksum the parser
// is ready for the next frame. Throughput is one character per clock:
// a character is captured in the input register, then decoded, counted
// and summed in short logic, and its result word enters the output
// register when that register has room. The output register decouples
// the two sides, so a new character is taken while a finished word
// waits; only a second digit that finds the output register full and
// stalled holds the input back.
module hex_ascii_command_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_value,
  output logic [1:0]      out_byte_kind,
  output logic [7:0]      out_data_index,
  output logic            out_frame_end,
  output logic            out_checksum_ok,
  output logic            out_command_known,
  output logic            out_hex_error,
  output logic            out_oversize
);
  import hacfp_pkg::*;

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_char_r;

  // Output register.
  logic       out_vld_r;
  result_t    out_res_r;

  logic [3:0] nibble;
  logic       nibble_bad;
  logic       second_digit;
  logic       res_fire;
  result_t    res;
  logic       out_free;
  logic       step;

  hacfp_hex_decode u_decode (
    .char_in (in_char_r),
    .nibble  (nibble),
    .bad     (nibble_bad)
  );

  // The output register is free when empty or when its word leaves now.
  assign out_free = !out_vld_r || !out_stall;

  // A first digit always moves on; a second digit needs room for its word.
  assign step = in_vld_r && (!second_digit || out_free);

  hacfp_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .nibble       (nibble),
    .nibble_bad   (nibble_bad),
    .second_digit (second_digit),
    .res_fire     (res_fire),
    .res          (res)
  );

  assign in_stall = in_vld_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_rx_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_byte_value    = out_res_r.byte_value;
  assign out_byte_kind     = out_res_r.byte_kind;
  assign out_data_index    = out_res_r.data_index;
  assign out_frame_end     = out_res_r.frame_end;
  assign out_checksum_ok   = out_res_r.checksum_ok;
  assign out_command_known = out_res_r.command_known;
  assign out_hex_error     = out_res_r.hex_error;
  assign out_oversize      = out_res_r.oversize;

endmodule

`default_nettype wire

// File: rtl/hacfp_checker.sv
// Port-level checks of the parser and the bind that attaches them.
`default_nettype none

module hacfp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_byte_kind,
  input wire logic [7:0] out_data_index,
  input wire logic       out_frame_end,
  input wire logic       out_checksum_ok,
  input wire logic       out_command_known
);
  import hacfp_pkg::*;

  // A stalled word stays on the channel.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Only the checksum word closes a frame, and it always does.
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (out_byte_kind == KIND_CHECKSUM)))
    else $error("frame_end does not match the checksum kind");

  // Frame verdicts appear only on the checksum word.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> !out_checksum_ok && !out_command_known)
    else $error("frame verdict outside the checksum word");

  // A data index is reported only for data words.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind != KIND_DATA) |-> out_data_index == 8'd0)
    else $error("data index on a non-data word");

endmodule

bind hex_ascii_command_frame_parser hacfp_checker u_hacfp_checker (.*);

`default_nettype wire

// File: tb/frame_parser_checker.sv
// Checker that predicts the result words of the frame parser and compares them.
module frame_parser_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_char,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte_value,
  input  wire logic [1:0] out_byte_kind,
  input  wire logic [7:0] out_data_index,
  input  wire logic       out_frame_end,
  input  wire logic       out_checksum_ok,
  input  wire logic       out_command_known,
  input  wire logic       out_hex_error,
  input  wire logic       out_oversize,
  output int unsigned     fail_count,
  output int unsigned     pending_count,
  output int unsigned     checked_count,
  output int unsigned     frame_count,
  output logic            between_frames
);
  import hacfp_pkg::*;

  // Mirror of the parser state.
  logic       low_digit_next;
  logic [3:0] upper_nibble;
  logic       upper_bad;
  frame_pos_t frame_pos;
  logic [7:0] data_seen;
  logic [7:0] length_byte;
  logic [7:0] byte_sum;
  logic [7:0] cmd_byte;

  result_t     decoded_bytes[$];
  result_t     oldest;

  // High when the next character starts the command byte of a new frame.
  assign between_frames = !low_digit_next && (frame_pos == POS_CMD);

  task automatic absorb_char(input logic [7:0] c);
    logic [3:0] nib;
    logic       bad;
    logic [7:0] value;
    logic [7:0] data_due;
    result_t    r;
    bad = 1'b0;
    if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
      nib = 4'(c - CHAR_DIGIT_LO);
    end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
      nib = 4'(c - OFFSET_UPPER);
    end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
      nib = 4'(c - OFFSET_LOWER);
    end else begin
      nib = 4'd0;
      bad = 1'b1;
    end
    if (!low_digit_next) begin
      upper_nibble   = nib;
      upper_bad      = bad;
      low_digit_next = 1'b1;
      return;
    end
    low_digit_next = 1'b0;
    value = {upper_nibble, nib};
    r = '0;
    r.byte_value = value;
    r.hex_error  = upper_bad | bad;
    data_due = (length_byte >= 8'(FRAME_OVERHEAD)) ? length_byte - 8'(FRAME_OVERHEAD) : 8'd0;
    case (frame_pos)
      POS_CMD: begin
        r.byte_kind = KIND_CMD;
        cmd_byte    = value;
        byte_sum    = value;
        frame_pos   = POS_LEN;
      end
      POS_LEN: begin
        r.byte_kind = KIND_LEN;
        length_byte = value;
        byte_sum    = byte_sum + value;
        r.oversize  = value > OVERSIZE_LIMIT;
        frame_pos   = POS_BODY;
      end
      default: begin
        if (data_seen < data_due) begin
          r.byte_kind  = KIND_DATA;
          r.data_index = data_seen;
          data_seen    = data_seen + 8'd1;
          byte_sum     = byte_sum + value;
        end else begin
          // The checksum byte itself is not part of the sum.
          r.byte_kind     = KIND_CHECKSUM;
          r.frame_end     = 1'b1;
          r.checksum_ok   = byte_sum == value;
          r.command_known = cmd_byte >= CMD_FIRST && cmd_byte <= CMD_LAST;
          r.oversize      = length_byte > OVERSIZE_LIMIT;
          frame_pos       = POS_CMD;
          data_seen       = 8'd0;
          byte_sum        = 8'd0;
        end
      end
    endcase
    decoded_bytes.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      low_digit_next = 1'b0;
      upper_nibble   = 4'd0;
      upper_bad      = 1'b0;
      frame_pos      = POS_CMD;
      data_seen      = 8'd0;
      length_byte    = 8'd0;
      byte_sum       = 8'd0;
      cmd_byte       = 8'd0;
      decoded_bytes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        absorb_char(in_rx_char);
      end
      if (out_valid && !out_stall) begin
        checked_count++;
        if (out_frame_end) begin
          frame_count++;
        end
        if (decoded_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected, actual value %0h kind %0d",
                   $time, out_byte_value, out_byte_kind);
        end else begin
          oldest = decoded_bytes.pop_front();
          check_field("byte_value", oldest.byte_value, out_byte_value);
          check_field("byte_kind", 8'(oldest.byte_kind), 8'(out_byte_kind));
          check_field("data_index", oldest.data_index, out_data_index);
          check_field("frame_end", 8'(oldest.frame_end), 8'(out_frame_end));
          check_field("checksum_ok", 8'(oldest.checksum_ok), 8'(out_checksum_ok));
          check_field("command_known", 8'(oldest.command_known), 8'(out_command_known));
          check_field("hex_error", 8'(oldest.hex_error), 8'(out_hex_error));
          check_field("oversize", 8'(oldest.oversize), 8'(out_oversize));
        end
      end
    end
    pending_count = decoded_bytes.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top of the frame parser: clock, reset, character stimulus and verdict.
module tb_top;
  import hacfp_pkg::*;

  // Characters in the random part, not counting the one long frame.
  localparam int unsigned RANDOM_CHARS = 360;
  // Characters that the long frame with length 0xFF adds (255 bytes, two digits each).
  localparam int unsigned LONG_CHARS   = 510;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned GARBLE_PCT   = 3;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_char = 8'd0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte_value;
  logic [1:0] out_byte_kind;
  logic [7:0] out_data_index;
  logic       out_frame_end;
  logic       out_checksum_ok;
  logic       out_command_known;
  logic       out_hex_error;
  logic       out_oversize;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned frame_count;
  logic        between_frames;

  int unsigned chars_sent;
  int unsigned frames_sent;
  int unsigned cycle_count;

  // While calm is set neither side idles, so the block runs at full rate.
  logic calm = 1'b0;

  // The opening characters cover the digit ranges, their neighbors below each range
  // and above 0-9 and A-F, a short length, a length with no data, a wrong checksum,
  // a frame made of bad digits only and a bad high digit on a known command.
  logic [7:0] opening_chars [26] = '{
    "0", "1", "0", "2", "0", "3",
    "9", "f", "0", "3", "F", "A",
    8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40, 8'h60,
    8'h47, "4", "0", "4", "a", "B", "b", "3"
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hex_ascii_command_frame_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_char        (in_rx_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_value    (out_byte_value),
    .out_byte_kind     (out_byte_kind),
    .out_data_index    (out_data_index),
    .out_frame_end     (out_frame_end),
    .out_checksum_ok   (out_checksum_ok),
    .out_command_known (out_command_known),
    .out_hex_error     (out_hex_error),
    .out_oversize      (out_oversize)
  );

  frame_parser_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_char        (in_rx_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_value    (out_byte_value),
    .out_byte_kind     (out_byte_kind),
    .out_data_index    (out_data_index),
    .out_frame_end     (out_frame_end),
    .out_checksum_ok   (out_checksum_ok),
    .out_command_known (out_command_known),
    .out_hex_error     (out_hex_error),
    .out_oversize      (out_oversize),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .frame_count       (frame_count),
    .between_frames    (between_frames)
  );

  // The receiver stalls on its own random schedule, independent of the sender.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // A hung handshake ends the run here rather than hanging the simulator.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words outstanding.",
               cycle_count, pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Letters come out in either case at random, so both spellings are exercised.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return CHAR_DIGIT_LO + 8'(n);
    if ($urandom_range(0, 1) == 1) return CHAR_UPPER_LO + 8'(n) - 8'd10;
    return CHAR_LOWER_LO + 8'(n) - 8'd10;
  endfunction

  // Offers one character as a word and returns at the falling edge after it was
  // taken. Every call starts and ends at a falling edge, so valid and the
  // payload change only there and get one assignment per time step.
  task automatic send_char(input logic [7:0] c);
    bit taken;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_char <= c;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  // A few digits get replaced by an arbitrary character. That flags a hex
  // error and can change a length, which the resync after each frame absorbs.
  task automatic send_byte(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = hex_digit(b[7:4]);
    lo = hex_digit(b[3:0]);
    if ($urandom_range(0, 99) < GARBLE_PCT) hi = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < GARBLE_PCT) lo = 8'($urandom_range(0, 255));
    send_char(hi);
    send_char(lo);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cmd + len;
    send_byte(cmd);
    send_byte(len);
    for (int i = 3; i < len; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    frames_sent++;
  endtask

  initial begin
    int unsigned budget;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  len;
    bit          long_done;

    // Synchronous reset held from the start, then released for good.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_chars[k]) begin
      send_char(opening_chars[k]);
    end

    // Random part: mostly whole frames with random content, some broken
    // ones (cut short or led by a stray character) and arbitrary characters.
    long_done = 1'b0;
    budget = chars_sent + RANDOM_CHARS;
    while (chars_sent < budget) begin
      calm <= (chars_sent >= 60) && (chars_sent < 200);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // A stray character that leaves the parser between the two digits.
        send_char(8'($urandom_range(0, 255)));
      end else if (pick < 8) begin
        // A frame cut off somewhere after its length byte.
        send_byte(8'($urandom_range(CMD_FIRST, CMD_LAST)));
        send_byte(8'($urandom_range(6, OVERSIZE_LIMIT)));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end else begin
        cmd = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(CMD_FIRST, CMD_LAST))
                                           : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (!long_done && chars_sent > 220) begin
          // The single frame with the largest length the byte can carry.
          len = 8'hFF;
          long_done = 1'b1;
          budget += LONG_CHARS;
        end else if (pick < 12) begin
          len = 8'($urandom_range(0, 2));
        end else if (pick < 25) begin
          len = 8'($urandom_range(OVERSIZE_LIMIT + 1, OVERSIZE_LIMIT + 7));
        end else begin
          len = 8'($urandom_range(3, OVERSIZE_LIMIT));
        end
        send_frame(cmd, len, $urandom_range(0, 99) < 25);
      end
      // Zero digits walk the parser to the start of the next frame: they pair
      // up a lone digit, fill missing data and close with a checksum.
      while (!between_frames) begin
        send_char(CHAR_DIGIT_LO);
      end
    end

    in_valid <= 1'b0;
    calm <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // Idle clocks follow so that a spurious extra word would still be caught.
    repeat (8) @(negedge clk);

    $display("Run covered %0d characters in %0d generated frames plus noise and resync digits.",
             chars_sent, frames_sent);
    $display("Compared %0d result words, %0d of them closing a frame.",
             checked_count, frame_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hacfp_pkg.sv
rtl/hacfp_hex_decode.sv
rtl/hacfp_framer.sv
rtl/hex_ascii_command_frame_parser.sv
rtl/hacfp_checker.sv
tb/frame_parser_checker.sv
tb/tb_top.sv
